FILE: rtl/core/bbpid_pkg.sv
// Shared types, fixed-point constants and helpers for the ball balance PID controller.
// Depends on nothing; used by bbpid_mul and the top level.
package bbpid_pkg;

  // Shared multiplier operand and product widths
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 27;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Filter factors, Q0.16
  localparam logic signed [MulBW-1:0] K070 = 27'sd45875;
  localparam logic signed [MulBW-1:0] K030 = 27'sd19661;
  localparam logic signed [MulBW-1:0] K095 = 27'sd62259;
  localparam logic signed [MulBW-1:0] K005 = 27'sd3277;
  localparam logic signed [MulBW-1:0] K085 = 27'sd55706;
  localparam logic signed [MulBW-1:0] K090 = 27'sd58982;
  // ceil(2^32 / 72): exact quotient for dividends below 2^27
  localparam logic signed [MulBW-1:0] RecipDiv72 = 27'sd59652324;

  localparam logic signed [63:0] OneQ16     = 64'sd65536;
  localparam logic signed [63:0] JumpMax    = 64'sd150;
  localparam logic signed [15:0] PosBound   = 16'sd500;
  localparam logic signed [15:0] VelBound   = 16'sd40;
  localparam logic [3:0]         LostMax    = 4'd8;
  localparam logic signed [63:0] DbInner    = 64'sd524288;    // 8 px
  localparam logic signed [63:0] DbSpanQ16  = 64'sd4718592;   // 72 px
  localparam logic signed [63:0] IntegZone  = 64'sd7864320;   // 120 px
  localparam logic signed [63:0] CenterSnap = 64'sd196608;    // 3 px
  localparam logic signed [63:0] AngleSnap  = 64'sd32768;     // 0.5 deg
  localparam logic signed [63:0] VelLow     = 64'sd98304;     // 1.5
  localparam logic signed [63:0] VelMid     = 64'sd196608;    // 3.0

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_PROP_GAIN   = 3'd1,
    CFG_INTEG_GAIN  = 3'd2,
    CFG_DERIV_GAIN  = 3'd3,
    CFG_INTEG_LIMIT = 3'd4,
    CFG_DERIV_LIMIT = 3'd5,
    CFG_ANGLE_LIMIT = 3'd6,
    CFG_SLEW_LIMIT  = 3'd7
  } cfg_idx_e;

  // Round to nearest Q16.16 (floor of v + 2^15, shifted)
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
                                                input logic signed [63:0] lim);
    logic signed [63:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [63:0] absv(input logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

FILE: rtl/core/bbpid_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bbpid_pkg for operand widths.
module bbpid_mul (
  input  logic                               clk_i,
  input  logic signed [bbpid_pkg::MulAW-1:0] a_i,
  input  logic signed [bbpid_pkg::MulBW-1:0] b_i,
  output logic signed [bbpid_pkg::MulPW-1:0] p_o
);
  import bbpid_pkg::*;

  logic signed [MulPW-1:0] p_q;

  // Product register, valid in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: rtl/core/ball_balance_pid_controller_top.sv
// Top level of the ball balance PID controller: frame sequencer and state.
// Depends on bbpid_pkg and bbpid_mul.

// One camera frame is one input transaction and gives one result transaction.
// A frame runs from acceptance to result as the sequencer steps through its
// states, which feed the single shared multiplier and take its registered
// product in a later state; the input is not ready while a frame is at
// work, and a finished frame holds in its last step while an
// earlier result still waits on the output. tdata in: position_raw [15:0],
// velocity_raw [31:16], time_step [47:32]; tuser in: ball_found. tdata out:
// angle_cmd [23:0]; tuser out: tracking_ok. Configuration writes take effect
// at once and belong between frames.
module ball_balance_pid_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [25:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // position_raw, velocity_raw, time_step
  input  logic        s_axis_tuser,   // ball_found
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // angle_cmd
  output logic        m_axis_tuser    // tracking_ok
);
  import bbpid_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_PF1, ST_PF2, ST_PF3, ST_VSEL, ST_VF1, ST_VF2, ST_VF3,
    ST_ERR, ST_DZ1, ST_DZ2, ST_I1, ST_I2, ST_I3, ST_D1, ST_D2, ST_D3,
    ST_LIM1, ST_LIM2, ST_CTR, ST_SLEW, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5,
    ST_FIN, ST_FIN2, ST_DONE
  } state_e;

  // Configuration
  logic signed [25:0] setpoint_q;
  logic [19:0] prop_gain_q, integ_gain_q;
  logic [22:0] deriv_gain_q, integ_limit_q, deriv_limit_q, angle_limit_q, slew_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q    <= '0;
      prop_gain_q   <= 20'd4260;
      integ_gain_q  <= 20'd6554;
      deriv_gain_q  <= 23'd216269;
      integ_limit_q <= 23'd196608;
      deriv_limit_q <= 23'd1048576;
      angle_limit_q <= 23'd589824;
      slew_limit_q  <= 23'd327680;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_SETPOINT:    setpoint_q    <= cfg_wdata_i;
        CFG_PROP_GAIN:   prop_gain_q   <= cfg_wdata_i[19:0];
        CFG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata_i[19:0];
        CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_wdata_i[22:0];
        CFG_INTEG_LIMIT: integ_limit_q <= cfg_wdata_i[22:0];
        CFG_DERIV_LIMIT: deriv_limit_q <= cfg_wdata_i[22:0];
        CFG_ANGLE_LIMIT: angle_limit_q <= cfg_wdata_i[22:0];
        CFG_SLEW_LIMIT:  slew_limit_q  <= cfg_wdata_i[22:0];
        default: ;
      endcase
    end
  end

  // Controller state and work registers
  state_e state_q;
  logic signed [31:0] pos_f_q, vel_f_q, integ_q, prev_angle_q;
  logic signed [15:0] prev_pos_q;
  logic [3:0]  lost_q;
  logic        track_q;
  logic signed [15:0] pos_q, vel_q;
  logic        found_q;
  logic [15:0] dt_q;
  logic signed [MulAW-1:0] err_q;
  logic signed [63:0] tmp_q, angle_q;
  logic        m_valid_q, m_track_q;
  logic [23:0] m_angle_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  bbpid_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic signed [63:0] p64, p_rnd, err_c, ae_c, ae_q, av_c, shift_c, lim_c, slew_c;
  logic signed [63:0] in_jump, ang_c, pf_c;
  logic signed [31:0] ang_sat_c;
  logic [3:0] limc;
  logic in_range, acc_ok;

  always_comb begin
    p64     = 64'(mul_p);
    p_rnd   = rnd16(p64);
    err_c   = 64'(pos_f_q) - 64'(setpoint_q);
    ae_c    = absv(err_c);
    ae_q    = absv(64'(err_q));
    av_c    = absv(64'(vel_f_q));
    shift_c = ae_q - DbInner;
    if (av_c < VelLow) limc = 4'd5;
    else if (av_c < VelMid) limc = 4'd7;
    else limc = 4'd9;
    lim_c   = 64'($signed({1'b0, limc})) * shift_c;
    in_range = found_q && (pos_q > -PosBound) && (pos_q < PosBound);
    in_jump  = absv(64'(pos_q) - 64'(prev_pos_q));
    acc_ok   = !track_q || (in_jump <= JumpMax);
    slew_c   = 64'(prev_angle_q)
             + clampv(angle_q - 64'(prev_angle_q), 64'(slew_limit_q));
    ang_c    = p_rnd + tmp_q + 64'(integ_q);
    pf_c     = 64'(sat32(p_rnd));
    ang_sat_c = sat32(angle_q);
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_PF1:  begin mul_a = MulAW'(pos_f_q); mul_b = K030; end
      ST_PF2:  begin mul_a = MulAW'(pos_q);   mul_b = K070; end
      ST_VF1:  begin mul_a = MulAW'(vel_f_q); mul_b = K005; end
      ST_VF2:  begin mul_a = MulAW'(vel_q);   mul_b = K095; end
      ST_DZ1:  begin mul_a = MulAW'(integ_q); mul_b = K085; end
      ST_I1:   begin mul_a = err_q; mul_b = MulBW'($signed({1'b0, dt_q})); end
      ST_I2:   begin mul_a = p_rnd[MulAW-1:0];
                     mul_b = MulBW'($signed({1'b0, integ_gain_q})); end
      ST_D1:   begin mul_a = MulAW'(vel_f_q);
                     mul_b = MulBW'($signed({1'b0, deriv_gain_q})); end
      ST_D2:   begin mul_a = err_q; mul_b = MulBW'($signed({1'b0, prop_gain_q})); end
      ST_LIM1: begin mul_a = lim_c[MulAW-1:0]; mul_b = RecipDiv72; end
      ST_L1:   begin mul_a = MulAW'(vel_f_q); mul_b = MulBW'($signed({1'b0, dt_q})); end
      ST_L2:   begin mul_a = MulAW'(vel_f_q); mul_b = K085; end
      ST_L4:   begin mul_a = MulAW'(pos_f_q); mul_b = K090; end
      ST_FIN:  begin mul_a = MulAW'(prev_angle_q); mul_b = K095; end
      default: ;
    endcase
  end

  // Frame sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_f_q      <= '0;
      vel_f_q      <= '0;
      integ_q      <= '0;
      prev_angle_q <= '0;
      prev_pos_q   <= '0;
      lost_q       <= '0;
      track_q      <= 1'b0;
      m_valid_q    <= 1'b0;
      m_track_q    <= 1'b0;
    end else begin
      // A result taken in the done step is replaced there
      if (m_valid_q && m_axis_tready && state_q != ST_DONE) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          pos_q   <= s_axis_tdata[15:0];
          vel_q   <= s_axis_tdata[31:16];
          dt_q    <= s_axis_tdata[47:32];
          found_q <= s_axis_tuser;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          angle_q <= 64'(prev_angle_q);
          if (in_range) prev_pos_q <= pos_q;
          if (in_range && acc_ok) state_q <= ST_PF1;
          else if (lost_q < LostMax) state_q <= ST_L1;
          else state_q <= ST_L4;
        end
        ST_PF1: state_q <= ST_PF2;
        ST_PF2: begin tmp_q <= p64; state_q <= ST_PF3; end
        ST_PF3: begin
          pos_f_q <= sat32(rnd16(tmp_q + (p64 <<< 16)));
          state_q <= ST_VSEL;
        end
        ST_VSEL: begin
          lost_q  <= '0;
          track_q <= 1'b1;
          if ((vel_q > -VelBound) && (vel_q < VelBound)) begin
            if (!track_q) begin
              vel_f_q <= {vel_q, 16'h0000};
              state_q <= ST_ERR;
            end else begin
              state_q <= ST_VF1;
            end
          end else begin
            state_q <= ST_ERR;
          end
        end
        ST_VF1: state_q <= ST_VF2;
        ST_VF2: begin tmp_q <= p64; state_q <= ST_VF3; end
        ST_VF3: begin
          vel_f_q <= sat32(rnd16(tmp_q + (p64 <<< 16)));
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          err_q <= err_c[MulAW-1:0];
          if (ae_c < DbInner) begin
            angle_q <= '0;
            state_q <= ST_DZ1;
          end else if (ae_c < IntegZone) begin
            state_q <= ST_I1;
          end else begin
            integ_q <= '0;
            state_q <= ST_D1;
          end
        end
        ST_DZ1: state_q <= ST_DZ2;
        ST_DZ2: begin integ_q <= sat32(p_rnd); state_q <= ST_SLEW; end
        ST_I1: state_q <= ST_I2;
        ST_I2: state_q <= ST_I3;
        ST_I3: begin
          integ_q <= sat32(clampv(64'(integ_q) + p_rnd, 64'(integ_limit_q)));
          state_q <= ST_D1;
        end
        ST_D1: state_q <= ST_D2;
        ST_D2: begin
          tmp_q   <= clampv(p_rnd, 64'(deriv_limit_q));
          state_q <= ST_D3;
        end
        ST_D3: begin
          angle_q <= clampv(ang_c, 64'(angle_limit_q));
          state_q <= ST_LIM1;
        end
        ST_LIM1: begin
          if (shift_c >= DbSpanQ16) begin
            tmp_q   <= 64'($signed({1'b0, limc})) <<< 16;
            state_q <= ST_CTR;
          end else begin
            state_q <= ST_LIM2;
          end
        end
        ST_LIM2: begin tmp_q <= p64 >>> 32; state_q <= ST_CTR; end
        ST_CTR: begin
          if ((err_q > 0 && angle_q < 0) || (err_q < 0 && angle_q > 0))
            angle_q <= clampv(angle_q, tmp_q);
          state_q <= ST_SLEW;
        end
        ST_SLEW: begin angle_q <= slew_c; state_q <= ST_FIN; end
        ST_L1: state_q <= ST_L2;
        ST_L2: begin
          pos_f_q <= sat32(64'(pos_f_q) + p_rnd);
          state_q <= ST_L3;
        end
        ST_L3: begin
          vel_f_q <= sat32(p_rnd);
          lost_q  <= lost_q + 4'd1;
          state_q <= ST_FIN;
        end
        ST_L4: state_q <= ST_L5;
        ST_L5: begin
          vel_f_q <= '0;
          if (pf_c < CenterSnap && pf_c > -CenterSnap) begin
            pos_f_q <= '0;
            lost_q  <= '0;
            track_q <= 1'b0;
          end else begin
            pos_f_q <= pf_c[31:0];
          end
          state_q <= ST_FIN;
        end
        ST_FIN: state_q <= track_q ? ST_DONE : ST_FIN2;
        ST_FIN2: begin
          if (p_rnd < AngleSnap && p_rnd > -AngleSnap) angle_q <= '0;
          else angle_q <= p_rnd;
          state_q <= ST_DONE;
        end
        // Hold here until the output register is free
        ST_DONE: if (!m_valid_q || m_axis_tready) begin
          prev_angle_q <= ang_sat_c;
          m_angle_q    <= ang_sat_c[23:0];
          m_track_q    <= track_q;
          m_valid_q    <= 1'b1;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_angle_q;
  assign m_axis_tuser  = m_track_q;

  // Checks
  a_lost_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_q <= LostMax) else $error("lost counter beyond limit");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_DONE) else $error("result outside done");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == ST_CHECK)
    else $error("accepted transaction did not start a frame");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(m_angle_q)))
    else $error("waiting result changed");

endmodule

FILE: tb/sv/tb_ball_balance_pid_controller_top.sv
// Testbench for ball_balance_pid_controller_top: frames in, angle commands out,
// checked against an in-bench fixed-point predictor. Depends on bbpid_pkg and the RTL.
module tb_ball_balance_pid_controller_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bbpid_pkg::*;

  localparam longint CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [25:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // position_raw, velocity_raw, time_step
  logic        s_axis_tuser = 1'b0; // ball_found
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // angle_cmd
  logic        m_axis_tuser;        // tracking_ok

  ball_balance_pid_controller_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor configuration and state
  longint setpt, kp, ki, kd, i_lim, d_lim, a_lim, s_lim;
  longint pos_f, vel_f, i_acc, prev_ang, last_pos;
  int     lost_n;
  bit     tracking;

  typedef struct packed {
    logic [23:0] angle;
    logic        trk;
  } angle_result_t;
  angle_result_t angle_q[$];

  int  errors = 0;
  bit  calm = 1'b0;  // no idling on either side
  longint cycles = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint q_rnd(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint q_sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q_clamp(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint q_abs(input longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic reset_predictor();
    setpt = 0; kp = 4260; ki = 6554; kd = 216269;
    i_lim = 196608; d_lim = 1048576; a_lim = 589824; s_lim = 327680;
    pos_f = 0; vel_f = 0; i_acc = 0; prev_ang = 0; last_pos = 0;
    lost_n = 0; tracking = 0;
  endtask

  // Predict the angle command for one camera frame
  task automatic predict_angle(input logic signed [15:0] p_raw,
                               input logic signed [15:0] v_raw,
                               input bit found, input logic [15:0] dts);
    longint pos, vel, dt, ang, err, ae, av, lim, dterm, shft, t, jump;
    bit ok;
    angle_result_t r;
    pos = p_raw; vel = v_raw; dt = dts; ang = prev_ang; ok = 0;
    if (found && pos > -500 && pos < 500) begin
      jump = q_abs(pos - last_pos);
      last_pos = pos;
      if (!tracking || jump <= 150) begin
        pos_f = q_sat(q_rnd(pos_f * 19661 + pos * 65536 * 45875));
        if (vel > -40 && vel < 40) begin
          if (!tracking) vel_f = vel * 65536;
          else vel_f = q_sat(q_rnd(vel_f * 3277 + vel * 65536 * 62259));
        end
        lost_n = 0; ok = 1; tracking = 1;
        err = pos_f - setpt;
        ae = q_abs(err);
        av = q_abs(vel_f);
        if (ae < 524288) begin
          ang = 0;
          i_acc = q_sat(q_rnd(i_acc * 55706));
        end else begin
          if (ae < 7864320) begin
            t = q_rnd(err * dt);
            t = q_rnd(t * ki);
            i_acc = q_sat(q_clamp(i_acc + t, i_lim));
          end else begin
            i_acc = 0;
          end
          dterm = q_clamp(q_rnd(kd * vel_f), d_lim);
          ang = q_clamp(q_rnd(kp * err) + dterm + i_acc, a_lim);
          if (av < 98304) lim = 5;
          else if (av < 196608) lim = 7;
          else lim = 9;
          shft = ae - 524288;
          if (shft >= 4718592) lim = lim * 65536;
          else lim = (lim * shft) / 72;
          if ((err > 0 && ang < 0) || (err < 0 && ang > 0)) ang = q_clamp(ang, lim);
        end
        ang = prev_ang + q_clamp(ang - prev_ang, s_lim);
      end
    end
    if (!ok) begin
      if (lost_n < 8) begin
        pos_f = q_sat(pos_f + q_rnd(vel_f * dt));
        vel_f = q_sat(q_rnd(vel_f * 55706));
        lost_n++;
      end else begin
        pos_f = q_sat(q_rnd(pos_f * 58982));
        if (pos_f < 196608 && pos_f > -196608) begin
          pos_f = 0; lost_n = 0; tracking = 0;
        end
        vel_f = 0;
      end
    end
    if (!tracking) begin
      ang = q_rnd(prev_ang * 62259);
      if (ang < 32768 && ang > -32768) ang = 0;
    end
    prev_ang = q_sat(ang);
    r.angle = prev_ang[23:0];
    r.trk = tracking;
    angle_q.push_back(r);
  endtask

  // Register write, only while idle
  task automatic write_reg(input cfg_idx_e idx, input longint val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_addr_i <= idx; cfg_wdata_i <= val[25:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SETPOINT:    setpt = longint'($signed(val[25:0]));
      CFG_PROP_GAIN:   kp = val[19:0];
      CFG_INTEG_GAIN:  ki = val[19:0];
      CFG_DERIV_GAIN:  kd = val[22:0];
      CFG_INTEG_LIMIT: i_lim = val[22:0];
      CFG_DERIV_LIMIT: d_lim = val[22:0];
      CFG_ANGLE_LIMIT: a_lim = val[22:0];
      default:         s_lim = val[22:0];
    endcase
  endtask

  task automatic wait_idle();
    while (angle_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // Send one frame; prediction happens at acceptance
  task automatic send_frame(input logic signed [15:0] p, input logic signed [15:0] v,
                            input bit found, input logic [15:0] dt);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 23) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {dt, v, p};
    s_axis_tuser <= found;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_angle(p, v, found, dt);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Result checking
  always @(posedge clk_i) begin
    angle_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angle_q.size() == 0) begin
        report("result with no frame pending");
      end else begin
        exp_r = angle_q.pop_front();
        if (m_axis_tdata !== exp_r.angle)
          report($sformatf("angle_cmd got %h want %h", m_axis_tdata, exp_r.angle));
        if (m_axis_tuser !== exp_r.trk)
          report($sformatf("tracking_ok got %b want %b", m_axis_tuser, exp_r.trk));
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 23);

  // Timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Directed: range limits, jump rejection, velocity gate, lost decay
  task automatic test_directed();
    send_frame(16'sd100, 16'sd10, 1'b1, 16'd655);
    send_frame(16'sd499, 16'sd39, 1'b1, 16'hFFFF);     // jump too far
    send_frame(16'sd200, -16'sd39, 1'b1, 16'd655);
    send_frame(16'sd210, 16'sd40, 1'b1, 16'd655);      // velocity out of range
    send_frame(16'sd500, 16'sd0, 1'b1, 16'd655);       // position out of range
    send_frame(-16'sd499, -16'sd40, 1'b1, 16'd655);
    send_frame(-16'sh8000, 16'sh7FFF, 1'b1, 16'd0);
    send_frame(16'sh7FFF, -16'sh8000, 1'b0, 16'hFFFF);
    send_frame(16'sd3, 16'sd0, 1'b1, 16'd655);
    send_frame(16'sd150, 16'sd2, 1'b1, 16'd655);       // large error, integral cleared
    for (int i = 0; i < 14; i++) send_frame(16'sd0, 16'sd0, 1'b0, 16'd655);
  endtask

  // Tracked walks with occasional noise
  task automatic test_random(input int n);
    logic signed [15:0] p, v;
    p = 0;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_frame(16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                      16'($urandom));
        1: send_frame(p, 16'(int'($urandom_range(80)) - 40), 1'b0, 16'($urandom));
        2: send_frame(16'(p + 16'sd200), 16'sd0, 1'b1, 16'($urandom_range(2000)));
        default: begin
          p = 16'(int'(p) + int'($urandom_range(60)) - 30);
          if (p > 499 || p < -499) p = 0;
          v = 16'(int'($urandom_range(78)) - 39);
          send_frame(p, v, 1'b1, 16'($urandom_range(3000)));
        end
      endcase
    end
  endtask

  // Configuration sweep over extremes
  task automatic test_configs();
    write_reg(CFG_SETPOINT, 32768000);
    write_reg(CFG_PROP_GAIN, 655360);
    write_reg(CFG_INTEG_GAIN, 655360);
    write_reg(CFG_DERIV_GAIN, 6553600);
    write_reg(CFG_INTEG_LIMIT, 5898240);
    write_reg(CFG_DERIV_LIMIT, 5898240);
    write_reg(CFG_ANGLE_LIMIT, 5898240);
    write_reg(CFG_SLEW_LIMIT, 5898240);
    test_random(250);
    wait_idle();
    write_reg(CFG_SETPOINT, -32768000);
    write_reg(CFG_PROP_GAIN, 0);
    write_reg(CFG_INTEG_GAIN, 0);
    write_reg(CFG_DERIV_GAIN, 0);
    write_reg(CFG_INTEG_LIMIT, 0);
    write_reg(CFG_DERIV_LIMIT, 0);
    write_reg(CFG_ANGLE_LIMIT, 0);
    write_reg(CFG_SLEW_LIMIT, 0);
    test_random(200);
    wait_idle();
    write_reg(CFG_SETPOINT, 20 * 65536);
    write_reg(CFG_PROP_GAIN, 40000);
    write_reg(CFG_INTEG_GAIN, 300000);
    write_reg(CFG_DERIV_GAIN, 500000);
    write_reg(CFG_INTEG_LIMIT, 2000000);
    write_reg(CFG_DERIV_LIMIT, 3000000);
    write_reg(CFG_ANGLE_LIMIT, 4000000);
    write_reg(CFG_SLEW_LIMIT, 1000000);
    calm = 1'b1;
    test_random(200);
    calm = 1'b0;
    test_random(150);
  endtask

  initial begin
    reset_predictor();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(700);
    wait_idle();
    test_configs();
    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: ball_balance_pid_controller_top.f
rtl/core/bbpid_pkg.sv
rtl/core/bbpid_mul.sv
rtl/core/ball_balance_pid_controller_top.sv
tb/sv/tb_ball_balance_pid_controller_top.sv
